@@ rtl/core/mddm_pkg.sv @@
package mddm_pkg;

    // Command codes
    localparam logic [2:0] FUNC_FORWARD  = 3'd0;
    localparam logic [2:0] FUNC_BACKWARD = 3'd1;
    localparam logic [2:0] FUNC_LEFT     = 3'd2;
    localparam logic [2:0] FUNC_RIGHT    = 3'd3;
    localparam logic [2:0] FUNC_SPIN     = 3'd4;
    localparam logic [2:0] FUNC_MOVE     = 3'd5;
    localparam logic [2:0] FUNC_STOP     = 3'd6;

    // Direction codes (two-bit signed)
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_ZERO = 2'b00;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    // Register indexes, taken from paddr[2]
    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_RATIO  = 1'b1;

    localparam int          ADDR_W       = 3;
    localparam logic [15:0] PERIOD_RESET = 16'd24000;
    localparam logic [8:0]  RATIO_RESET  = 9'd154;
    localparam logic [8:0]  RATIO_MAX    = 9'd256;

    // Full scale speed in Q8 (100 steps * 256)
    localparam logic [15:0] FULL_Q8 = 16'd25600;

    // duty = period * off / 51200 = ((period * off) >> 11) / 25
    // The divide by 25 is a multiply by ceil(2^26 / 25) and a shift by 26,
    // exact for quotients below 2^21.
    localparam int          PRE_SHIFT   = 11;
    localparam int          RECIP_SHIFT = 26;
    localparam int          RECIP_W     = 22;
    localparam logic [21:0] RECIP_MUL   = 22'd2684355;

    localparam int NUM_WHEELS = 4;

    typedef logic signed [15:0] wheel_q8_t;
    typedef logic [31:0]        wheel_prod_t;
    typedef logic [15:0]        wheel_duty_t;

    // Clip a nine-bit signed value to +-100
    function automatic logic signed [7:0] sat100(input logic signed [8:0] v);
        logic signed [7:0] r;
        if (v > 9'sd100)
            r = 8'sd100;
        else if (v < -9'sd100)
            r = -8'sd100;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

@@ rtl/core/mddm_if.sv @@
interface mddm_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    logic signed [7:0] speed;
    logic signed [1:0] dir;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;

    modport source (output valid, func, speed, dir, stick_x, stick_y, input ready);
    modport sink   (input valid, func, speed, dir, stick_x, stick_y, output ready);
endinterface

interface mddm_duty_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty_front_left;
    logic [15:0] duty_front_right;
    logic [15:0] duty_rear_left;
    logic [15:0] duty_rear_right;
    logic [3:0]  wheel_enables;

    modport source (output valid, duty_front_left, duty_front_right, duty_rear_left,
                    duty_rear_right, wheel_enables, input ready);
    modport sink   (input valid, duty_front_left, duty_front_right, duty_rear_left,
                    duty_rear_right, wheel_enables, output ready);
endinterface

@@ rtl/core/mecanum_drive_duty_mixer.sv @@
// Channel  | Dir | Words                                   | Handshake
// cmd      | in  | func, speed, dir, stick_x, stick_y      | valid/ready
// duty     | out | four wheel compare values, wheel_enables | valid/ready
// apb      | in  | period at 0x0, move_ratio at 0x4        | psel/penable, pready=1
//
// Three register stages: command decode and ratio multiply, period multiply,
// divide by 51200 as a reciprocal multiply. One word is
// taken every cycle while the output side keeps up.
// rst_n clears the valid bits and loads the register reset values.
// A stall holds the output word; each stage keeps taking words while it or
// the stage after it is free, so bubbles close up and nothing is dropped.
module mecanum_drive_duty_mixer (
    input  logic                          clk,
    input  logic                          rst_n,
    mddm_cmd_if.sink                      cmd,
    mddm_duty_if.source                   duty,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mddm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int NW = mddm_pkg::NUM_WHEELS;

    logic [15:0] period_reg;
    logic [8:0]  move_ratio_reg;

    logic        v1_reg, v2_reg, v3_reg;
    logic        ready1, ready2, ready3;

    mddm_pkg::wheel_q8_t   [NW-1:0] spd_next, spd_reg;
    mddm_pkg::wheel_prod_t [NW-1:0] prod_next, prod_reg;
    mddm_pkg::wheel_duty_t [NW-1:0] duty_next, duty_reg;
    logic [NW-1:0] en1_next, en1_reg, en2_reg, en3_reg;

    logic signed [7:0]  speed_sat;
    logic signed [15:0] v_pos, v_neg;
    logic signed [7:0]  move_a, move_b;
    logic [8:0]         ratio_sat;
    logic signed [17:0] prod_a, prod_b;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= mddm_pkg::PERIOD_RESET;
            move_ratio_reg <= mddm_pkg::RATIO_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == mddm_pkg::REG_PERIOD)
                period_reg <= pwdata[15:0];
            else
                move_ratio_reg <= pwdata[8:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == mddm_pkg::REG_PERIOD)
            prdata = {16'd0, period_reg};
        else
            prdata = {23'd0, move_ratio_reg};
    end

    // Stage advance: a stage takes a word when it is empty or is emptying
    assign ready3    = !v3_reg || duty.ready;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign cmd.ready = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= cmd.valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
        end
    end

    // Stage 1: decode the command into four Q8 wheel speeds
    assign speed_sat = mddm_pkg::sat100({cmd.speed[7], cmd.speed});
    assign v_pos     = {speed_sat, 8'h00};
    assign v_neg     = -v_pos;
    assign move_a    = mddm_pkg::sat100({cmd.stick_y[7], cmd.stick_y}
                                        + {cmd.stick_x[7], cmd.stick_x});
    assign move_b    = mddm_pkg::sat100({cmd.stick_y[7], cmd.stick_y}
                                        - {cmd.stick_x[7], cmd.stick_x});
    assign ratio_sat = (move_ratio_reg > mddm_pkg::RATIO_MAX) ? mddm_pkg::RATIO_MAX
                                                               : move_ratio_reg;
    assign prod_a    = move_a * $signed({1'b0, ratio_sat});
    assign prod_b    = move_b * $signed({1'b0, ratio_sat});

    always_comb
    begin
        spd_next = '0;
        case (cmd.func)
            mddm_pkg::FUNC_FORWARD:
            begin
                spd_next = {NW{v_pos}};
            end
            mddm_pkg::FUNC_BACKWARD:
            begin
                spd_next = {NW{v_neg}};
            end
            mddm_pkg::FUNC_LEFT:
            begin
                if (cmd.dir inside {mddm_pkg::DIR_POS, mddm_pkg::DIR_ZERO})
                begin
                    spd_next[1] = v_pos;
                    spd_next[2] = v_pos;
                end
                if (cmd.dir inside {mddm_pkg::DIR_NEG, mddm_pkg::DIR_ZERO})
                begin
                    spd_next[0] = v_neg;
                    spd_next[3] = v_neg;
                end
            end
            mddm_pkg::FUNC_RIGHT:
            begin
                if (cmd.dir inside {mddm_pkg::DIR_POS, mddm_pkg::DIR_ZERO})
                begin
                    spd_next[0] = v_pos;
                    spd_next[3] = v_pos;
                end
                if (cmd.dir inside {mddm_pkg::DIR_NEG, mddm_pkg::DIR_ZERO})
                begin
                    spd_next[1] = v_neg;
                    spd_next[2] = v_neg;
                end
            end
            mddm_pkg::FUNC_SPIN:
            begin
                if (cmd.dir == mddm_pkg::DIR_POS)
                begin
                    spd_next[0] = v_pos;
                    spd_next[2] = v_pos;
                    spd_next[1] = v_neg;
                    spd_next[3] = v_neg;
                end
                else
                begin
                    spd_next[0] = v_neg;
                    spd_next[2] = v_neg;
                    spd_next[1] = v_pos;
                    spd_next[3] = v_pos;
                end
            end
            mddm_pkg::FUNC_MOVE:
            begin
                spd_next[0] = prod_a[15:0];
                spd_next[3] = prod_a[15:0];
                spd_next[1] = prod_b[15:0];
                spd_next[2] = prod_b[15:0];
            end
            default:
            begin
                spd_next = '0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NW; i++)
            en1_next[i] = (spd_next[i] != '0);
    end

    // Stage 2: offset the speed to 0..51200 and scale by the period
    always_comb
    begin
        logic [15:0] offset;
        for (int i = 0; i < NW; i++)
        begin
            offset       = 16'(spd_reg[i] + mddm_pkg::FULL_Q8);
            prod_next[i] = period_reg * offset;
        end
    end

    // Stage 3: divide by 51200 through the reciprocal multiply
    always_comb
    begin
        logic [31-mddm_pkg::PRE_SHIFT:0]                    quot;
        logic [31-mddm_pkg::PRE_SHIFT+mddm_pkg::RECIP_W:0]  scaled;
        for (int i = 0; i < NW; i++)
        begin
            quot         = prod_reg[i][31:mddm_pkg::PRE_SHIFT];
            scaled       = quot * mddm_pkg::RECIP_MUL;
            duty_next[i] = scaled[mddm_pkg::RECIP_SHIFT +: 16];
        end
    end

    // Payload registers: load on advance, hold on stall
    always_ff @(posedge clk)
    begin
        if (ready1 && cmd.valid)
        begin
            spd_reg <= spd_next;
            en1_reg <= en1_next;
        end
        if (ready2 && v1_reg)
        begin
            prod_reg <= prod_next;
            en2_reg  <= en1_reg;
        end
        if (ready3 && v2_reg)
        begin
            duty_reg <= duty_next;
            en3_reg  <= en2_reg;
        end
    end

    assign duty.valid            = v3_reg;
    assign duty.duty_front_left  = duty_reg[0];
    assign duty.duty_front_right = duty_reg[1];
    assign duty.duty_rear_left   = duty_reg[2];
    assign duty.duty_rear_right  = duty_reg[3];
    assign duty.wheel_enables    = en3_reg;

endmodule

@@ rtl/core/mddm_checker.sv @@
module mddm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [mddm_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [15:0]                 duty_fl,
    input logic [15:0]                 duty_fr,
    input logic [15:0]                 duty_rl,
    input logic [15:0]                 duty_rr,
    input logic [3:0]                  wheel_enables
);

    logic [15:0] period_reg;
    logic [15:0] period_next;
    logic [15:0] half_period;

    // Mirror the period register from the bus writes
    always_comb
    begin
        period_next = period_reg;
        if (psel && penable && pwrite && paddr[2] == mddm_pkg::REG_PERIOD)
            period_next = pwdata[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= mddm_pkg::PERIOD_RESET;
        else
            period_reg <= period_next;
    end

    assign half_period = period_reg >> 1;

    // Hold a stalled word
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(duty_fl) && $stable(duty_fr)
                                    && $stable(duty_rl) && $stable(duty_rr)
                                    && $stable(wheel_enables))
        else $error("output word changed while stalled");

    // A wheel at rest sits at half the period
    a_rest_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (wheel_enables[0] || duty_fl == half_period)
                   && (wheel_enables[1] || duty_fr == half_period)
                   && (wheel_enables[2] || duty_rl == half_period)
                   && (wheel_enables[3] || duty_rr == half_period))
        else $error("disabled wheel not at half period");

    // No duty exceeds the period
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_fl <= period_reg && duty_fr <= period_reg
                   && duty_rl <= period_reg && duty_rr <= period_reg)
        else $error("duty above period");

endmodule

bind mecanum_drive_duty_mixer mddm_checker u_mddm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .out_valid     (duty.valid),
    .out_ready     (duty.ready),
    .duty_fl       (duty.duty_front_left),
    .duty_fr       (duty.duty_front_right),
    .duty_rl       (duty.duty_rear_left),
    .duty_rr       (duty.duty_rear_right),
    .wheel_enables (duty.wheel_enables)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    // Codes that have no name in the package
    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam logic [1:0] DIR_NEG_TWO = 2'b10;

    // Register byte addresses
    localparam logic [mddm_pkg::ADDR_W-1:0] ADDR_PERIOD = {mddm_pkg::REG_PERIOD, 2'b00};
    localparam logic [mddm_pkg::ADDR_W-1:0] ADDR_RATIO  = {mddm_pkg::REG_RATIO, 2'b00};

    localparam int PIPE_DEPTH  = 3;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 155;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [2:0]        func;
        logic signed [7:0] speed;
        logic signed [1:0] dir;
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
    } drive_cmd_t;

    typedef struct {
        logic [15:0] fl;
        logic [15:0] fr;
        logic [15:0] rl;
        logic [15:0] rr;
        logic [3:0]  en;
    } duty_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [mddm_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    mddm_cmd_if  cmd_bus ();
    mddm_duty_if duty_bus ();

    // Local copy of the two registers
    logic [15:0] cfg_period = mddm_pkg::PERIOD_RESET;
    logic [8:0]  cfg_ratio = mddm_pkg::RATIO_RESET;

    drive_cmd_t pending_cmds [$];
    duty_word_t expected_duty [$];

    bit          idle_on = 1'b1;
    int unsigned send_gap;
    int unsigned recv_gap;
    int          error_count = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          settings_used = 1;
    int          func_count [8];
    int          cycle_count = 0;

    mecanum_drive_duty_mixer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus.sink),
        .duty    (duty_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // Clip a wheel speed to +-100 steps
    function automatic int clip_speed(int v);
        if (v > 100)
            return 100;
        if (v < -100)
            return -100;
        return v;
    endfunction

    // Map a Q8 wheel speed onto the PWM compare range
    function automatic logic [15:0] duty_from_speed(int s);
        longint unsigned prod;
        prod = longint'(cfg_period) * longint'(s + int'(mddm_pkg::FULL_Q8));
        return 16'(prod / (2 * longint'(mddm_pkg::FULL_Q8)));
    endfunction

    // Wheel speeds of one command, then duties and enables
    function automatic duty_word_t mix_wheels(drive_cmd_t c);
        int v;
        int ratio;
        int a;
        int b;
        int w [4];
        duty_word_t d;
        v = clip_speed(int'(c.speed)) * 256;
        ratio = (cfg_ratio > mddm_pkg::RATIO_MAX) ? int'(mddm_pkg::RATIO_MAX)
                                                  : int'(cfg_ratio);
        // order: front left, front right, rear left, rear right
        w = '{0, 0, 0, 0};
        case (c.func)
            mddm_pkg::FUNC_FORWARD: w = '{v, v, v, v};
            mddm_pkg::FUNC_BACKWARD: w = '{-v, -v, -v, -v};
            mddm_pkg::FUNC_LEFT:
            begin
                if (c.dir == mddm_pkg::DIR_POS || c.dir == mddm_pkg::DIR_ZERO)
                begin
                    w[1] = v;
                    w[2] = v;
                end
                if (c.dir == mddm_pkg::DIR_NEG || c.dir == mddm_pkg::DIR_ZERO)
                begin
                    w[0] = -v;
                    w[3] = -v;
                end
            end
            mddm_pkg::FUNC_RIGHT:
            begin
                if (c.dir == mddm_pkg::DIR_POS || c.dir == mddm_pkg::DIR_ZERO)
                begin
                    w[0] = v;
                    w[3] = v;
                end
                if (c.dir == mddm_pkg::DIR_NEG || c.dir == mddm_pkg::DIR_ZERO)
                begin
                    w[1] = -v;
                    w[2] = -v;
                end
            end
            mddm_pkg::FUNC_SPIN:
            begin
                if (c.dir == mddm_pkg::DIR_POS)
                    w = '{v, -v, v, -v};
                else
                    w = '{-v, v, -v, v};
            end
            mddm_pkg::FUNC_MOVE:
            begin
                a = clip_speed(int'(c.stick_y) + int'(c.stick_x)) * ratio;
                b = clip_speed(int'(c.stick_y) - int'(c.stick_x)) * ratio;
                w = '{a, b, b, a};
            end
            default: ;
        endcase
        d.fl = duty_from_speed(w[0]);
        d.fr = duty_from_speed(w[1]);
        d.rl = duty_from_speed(w[2]);
        d.rr = duty_from_speed(w[3]);
        d.en = {w[3] != 0, w[2] != 0, w[1] != 0, w[0] != 0};
        return d;
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (!idle_on || pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Joystick value, biased toward the corners of the range
    function automatic logic [7:0] stick_value();
        case ($urandom_range(0, 9))
            0: return 8'h80;
            1: return 8'h7f;
            2: return 8'h9c;
            3: return 8'h64;
            4: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic drive_cmd_t random_cmd();
        drive_cmd_t c;
        c.func = ($urandom_range(0, 99) < 30) ? mddm_pkg::FUNC_MOVE
                                              : 3'($urandom_range(0, 7));
        if ($urandom_range(0, 6) == 0)
            c.speed = 8'($urandom);
        else
            c.speed = 8'(int'($urandom_range(0, 200)) - 100);
        c.dir = 2'($urandom);
        c.stick_x = stick_value();
        c.stick_y = stick_value();
        return c;
    endfunction

    task automatic push_cmd(input logic [2:0] func, input logic [7:0] speed,
                            input logic [1:0] dir, input logic [7:0] sx,
                            input logic [7:0] sy);
        drive_cmd_t c;
        c.func = func;
        c.speed = speed;
        c.dir = dir;
        c.stick_x = sx;
        c.stick_y = sy;
        pending_cmds.push_back(c);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // One APB transfer: setup cycle, then access cycle
    task automatic apb_cycle(input logic wr, input logic [mddm_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Write both registers, then read them back
    task automatic set_config(input logic [15:0] period, input logic [8:0] ratio);
        logic [31:0] rdata;
        apb_cycle(1'b1, ADDR_PERIOD, {16'd0, period}, rdata);
        cfg_period = period;
        apb_cycle(1'b1, ADDR_RATIO, {23'd0, ratio}, rdata);
        cfg_ratio = ratio;
        apb_cycle(1'b0, ADDR_PERIOD, 32'd0, rdata);
        check_field("period readback", cfg_period, rdata[15:0]);
        apb_cycle(1'b0, ADDR_RATIO, 32'd0, rdata);
        check_field("move_ratio readback", 16'(cfg_ratio), rdata[15:0]);
        settings_used++;
    endtask

    // Hold until every command is in and every duty word is out
    task automatic wait_idle();
        @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_bus.valid || expected_duty.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Command driver: present queued words with random gaps
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        drive_cmd_t c;
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.func <= mddm_pkg::FUNC_STOP;
            cmd_bus.speed <= '0;
            cmd_bus.dir <= mddm_pkg::DIR_ZERO;
            cmd_bus.stick_x <= '0;
            cmd_bus.stick_y <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                c.func = cmd_bus.func;
                c.speed = cmd_bus.speed;
                c.dir = cmd_bus.dir;
                c.stick_x = cmd_bus.stick_x;
                c.stick_y = cmd_bus.stick_y;
                expected_duty.push_back(mix_wheels(c));
                words_sent++;
                func_count[c.func]++;
            end
            if (cmd_bus.valid && !cmd_bus.ready)
            begin
                // hold the word until taken
            end
            else if (send_gap != 0)
            begin
                cmd_bus.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_cmds.size() != 0)
            begin
                c = pending_cmds.pop_front();
                cmd_bus.func <= c.func;
                cmd_bus.speed <= c.speed;
                cmd_bus.dir <= c.dir;
                cmd_bus.stick_x <= c.stick_x;
                cmd_bus.stick_y <= c.stick_y;
                cmd_bus.valid <= 1'b1;
                send_gap <= idle_len();
            end
            else
                cmd_bus.valid <= 1'b0;
        end
    end

    // Duty monitor: stall at random, check each word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : duty_monitor
        duty_word_t d;
        if (!rst_n)
        begin
            duty_bus.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (duty_bus.valid && duty_bus.ready)
            begin
                if (expected_duty.size() == 0)
                begin
                    $error("duty word with no command pending");
                    error_count++;
                end
                else
                begin
                    d = expected_duty.pop_front();
                    check_field("duty_front_left", d.fl, duty_bus.duty_front_left);
                    check_field("duty_front_right", d.fr, duty_bus.duty_front_right);
                    check_field("duty_rear_left", d.rl, duty_bus.duty_rear_left);
                    check_field("duty_rear_right", d.rr, duty_bus.duty_rear_right);
                    check_field("wheel_enables", 16'(d.en), 16'(duty_bus.wheel_enables));
                    words_checked++;
                end
            end
            if (recv_gap != 0)
            begin
                duty_bus.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                duty_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_gap <= idle_len();
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] period;
        logic [8:0]  ratio;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands at reset register values
        push_cmd(mddm_pkg::FUNC_FORWARD, 8'd100, mddm_pkg::DIR_ZERO, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_FORWARD, 8'h7f, mddm_pkg::DIR_ZERO, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_FORWARD, 8'h00, mddm_pkg::DIR_ZERO, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_BACKWARD, 8'h9c, mddm_pkg::DIR_POS, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_BACKWARD, 8'h80, mddm_pkg::DIR_NEG, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_LEFT, 8'd60, mddm_pkg::DIR_ZERO, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_LEFT, 8'd60, mddm_pkg::DIR_POS, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_LEFT, 8'd60, mddm_pkg::DIR_NEG, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_LEFT, 8'd60, DIR_NEG_TWO, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_RIGHT, 8'hc4, mddm_pkg::DIR_ZERO, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_RIGHT, 8'hc4, mddm_pkg::DIR_POS, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_RIGHT, 8'hc4, mddm_pkg::DIR_NEG, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_RIGHT, 8'hc4, DIR_NEG_TWO, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_SPIN, 8'd50, mddm_pkg::DIR_POS, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_SPIN, 8'hb3, mddm_pkg::DIR_ZERO, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_SPIN, 8'd100, DIR_NEG_TWO, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_MOVE, 8'h00, mddm_pkg::DIR_ZERO, 8'h7f, 8'h7f);
        push_cmd(mddm_pkg::FUNC_MOVE, 8'h00, mddm_pkg::DIR_ZERO, 8'h80, 8'h7f);
        push_cmd(mddm_pkg::FUNC_MOVE, 8'h00, mddm_pkg::DIR_ZERO, 8'h80, 8'h80);
        push_cmd(mddm_pkg::FUNC_MOVE, 8'h00, mddm_pkg::DIR_ZERO, 8'h00, 8'h00);
        push_cmd(mddm_pkg::FUNC_MOVE, 8'h00, mddm_pkg::DIR_ZERO, 8'd37, 8'hec);
        push_cmd(mddm_pkg::FUNC_STOP, 8'd100, mddm_pkg::DIR_POS, 8'h7f, 8'h7f);
        push_cmd(FUNC_UNUSED, 8'd100, mddm_pkg::DIR_NEG, 8'h80, 8'h7f);
        wait_idle();

        // Random phases over a range of register settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin period = 16'd1;     ratio = mddm_pkg::RATIO_MAX; end
                1: begin period = 16'hffff;  ratio = 9'd0;      end
                2: begin period = 16'd0;     ratio = 9'h1ff;    end
                3:
                begin
                    period = mddm_pkg::PERIOD_RESET;
                    ratio = mddm_pkg::RATIO_RESET;
                end
                4: begin period = 16'hffff;  ratio = mddm_pkg::RATIO_MAX; end
                5: begin period = 16'd2;     ratio = 9'd1;      end
                6: begin period = 16'd51200; ratio = 9'd300;    end
                default:
                begin
                    period = 16'($urandom);
                    ratio = 9'($urandom);
                end
            endcase
            idle_on = (ph % 4 != 3);
            set_config(period, ratio);
            // two batches, the sender waiting for every duty word in between
            for (int batch = 0; batch < 2; batch++)
            begin
                for (int i = 0; i < PHASE_ITEMS / 2; i++)
                    pending_cmds.push_back(random_cmd());
                wait_idle();
            end
        end

        repeat (PIPE_DEPTH + 10) @(posedge clk);
        $display("Ran %0d drive commands through %0d register settings; %0d duty words checked.",
                 words_sent, settings_used, words_checked);
        $display("Commands by code: fwd %0d back %0d left %0d right %0d spin %0d",
                 func_count[0], func_count[1], func_count[2], func_count[3],
                 func_count[4]);
        $display("  move %0d stop %0d unused %0d",
                 func_count[5], func_count[6], func_count[7]);
        if (error_count == 0 && expected_duty.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
